[design/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on clk_i, off during reset
`define RCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication check on clk_i, off during reset
`define RCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

[design/rcr_pkg.sv]
// types, constants and codes of the residue class reachable count block
package rcr_pkg;

  localparam int unsigned RESIDUE_TABLE_SIZE_DEF = 1024;
  localparam int unsigned HW = 63;
  localparam int unsigned MW = 11;
  localparam int unsigned SW = 20;
  localparam int unsigned DIV_STEPS = 63;
  localparam int unsigned DCW = 6;

  typedef struct packed {
    logic [HW-1:0] height_limit;
    logic [MW-1:0] modulus_step;
    logic [SW-1:0] second_step;
    logic [SW-1:0] third_step;
  } rcr_in_t;

  typedef struct packed {
    logic [HW-1:0] reachable_count;
    logic          modulus_too_large;
  } rcr_out_t;

  typedef enum logic [1:0] {
    DIV_H = 2'd0,
    DIV_Y = 2'd1,
    DIV_Z = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_sel_e div_sel;
    logic     idx_clr;
    logic     idx_inc;
    logic     mem_clear;
    logic     mem_seed;
    logic     scan_rd;
    logic     best_clr;
    logic     settle_wr;
    logic     rd_y;
    logic     wr_y;
    logic     rd_z;
    logic     wr_z;
    logic     sum_rd;
    logic     total_clr;
    logic     load_out;
  } rcr_cmd_t;

  typedef struct packed {
    logic special;
    logic div_done;
    logic idx_last;
    logic found;
    logic out_free;
  } rcr_sts_t;

endpackage

[design/rcr_div.sv]
// restoring divider, one quotient bit per cycle
module rcr_div import rcr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [HW-1:0] dividend_i,
  input  logic [MW-1:0] divisor_i,
  output logic          done_o,
  output logic [HW-1:0] quotient_o,
  output logic [MW-1:0] remainder_o
);

  logic           busy_q;
  logic           done_q;
  logic [DCW-1:0] cnt_q;
  logic [HW-1:0]  dvd_q;
  logic [HW-1:0]  quo_q;
  logic [MW-1:0]  rem_q;
  logic [MW-1:0]  dsr_q;
  logic [MW:0]    trial;
  logic           ge;
  logic           last;

  assign trial = {rem_q, dvd_q[HW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign last  = cnt_q == DCW'(DIV_STEPS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DCW'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[HW-2:0], 1'b0};
      quo_q <= {quo_q[HW-2:0], ge};
      rem_q <= ge ? MW'(trial - {1'b0, dsr_q}) : trial[MW-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[design/rcr_dp.sv]
// datapath: item registers, divider, residue memory, scan and sum
module rcr_dp import rcr_pkg::*; #(
  parameter int unsigned RESIDUE_TABLE_SIZE = RESIDUE_TABLE_SIZE_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rcr_in_t  in_data_i,
  input  logic     out_ready_i,
  input  rcr_cmd_t cmd_i,
  output rcr_sts_t sts_o,
  output logic     out_valid_o,
  output rcr_out_t out_data_o
);

  localparam int unsigned IW = (RESIDUE_TABLE_SIZE > 1) ? $clog2(RESIDUE_TABLE_SIZE) : 1;
  localparam int unsigned XW = IW + 1;

  typedef struct packed {
    logic        settled;
    logic        reached;
    logic [31:0] k;
    logic [31:0] d;
  } entry_t;

  rcr_in_t       item_q;
  logic [MW-1:0] x;
  logic          unit_c, xzero_c, too_c;
  logic [IW-1:0] xm1;
  logic [IW-1:0] idx_q;

  // divider
  logic          div_done;
  logic [HW-1:0] div_quo;
  logic [MW-1:0] div_rem;
  logic [HW-1:0] div_dvd;
  div_sel_e      div_sel_q;
  logic [HW-1:0] q_h_q;
  logic [MW-1:0] r_h_q;
  logic [SW-1:0] q_y_q, q_z_q;
  logic [IW-1:0] r_y_q, r_z_q;

  // memory
  entry_t        mem_q [RESIDUE_TABLE_SIZE];
  entry_t        rdata_q;
  logic          rd_en, we;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wdata;

  // search
  logic          found_q;
  logic [IW-1:0] best_idx_q;
  logic [31:0]   best_k_q, best_d_q;
  logic          scan_v_q, sum_v_q, acc_v_q;
  logic [IW-1:0] eval_idx_q;

  // relax
  logic          use_z;
  logic [SW-1:0] step, q_s;
  logic [IW-1:0] r_s, to_s;
  logic [XW-1:0] add_s;
  logic          c_s;
  logic [31:0]   nk;
  logic [32:0]   nd;
  logic          better;

  // sum
  logic          in_range;
  logic [HW-1:0] addend_q, total_q;
  logic          out_valid_q;
  rcr_out_t      out_data_q;

  assign x       = item_q.modulus_step;
  assign unit_c  = (x == MW'(1)) || (item_q.second_step == SW'(1)) ||
                   (item_q.third_step == SW'(1));
  assign xzero_c = x == '0;
  assign too_c   = 32'(x) > RESIDUE_TABLE_SIZE;
  assign xm1     = IW'(x - MW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_H:   div_dvd = item_q.height_limit;
      DIV_Y:   div_dvd = HW'(item_q.second_step);
      DIV_Z:   div_dvd = HW'(item_q.third_step);
      default: div_dvd = item_q.height_limit;
    endcase
  end

  rcr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (x),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_sel_q <= cmd_i.div_sel;
    end
    if (div_done) begin
      unique case (div_sel_q)
        DIV_H: begin
          q_h_q <= div_quo;
          r_h_q <= div_rem;
        end
        DIV_Y: begin
          q_y_q <= div_quo[SW-1:0];
          r_y_q <= IW'(div_rem);
        end
        DIV_Z: begin
          q_z_q <= div_quo[SW-1:0];
          r_z_q <= IW'(div_rem);
        end
        default: begin
          q_h_q <= div_quo;
          r_h_q <= div_rem;
        end
      endcase
    end
  end

  // target residue and path for one edge out of the settled residue
  assign use_z  = cmd_i.rd_z || cmd_i.wr_z;
  assign step   = use_z ? item_q.third_step : item_q.second_step;
  assign q_s    = use_z ? q_z_q : q_y_q;
  assign r_s    = use_z ? r_z_q : r_y_q;
  assign add_s  = XW'(best_idx_q) + XW'(r_s);
  assign c_s    = add_s >= XW'(x);
  assign to_s   = c_s ? IW'(add_s - XW'(x)) : IW'(add_s);
  assign nk     = best_k_q + 32'(q_s) + 32'(c_s);
  assign nd     = 33'(best_d_q) + 33'(step);
  assign better = !rdata_q.reached || (nd < 33'(rdata_q.d));

  always_comb begin
    rd_en   = cmd_i.scan_rd || cmd_i.sum_rd || cmd_i.rd_y || cmd_i.rd_z;
    rd_addr = (cmd_i.rd_y || cmd_i.rd_z) ? to_s : idx_q;
    we      = 1'b0;
    wr_addr = idx_q;
    wdata   = '0;
    priority if (cmd_i.mem_clear) begin
      we = 1'b1;
    end else if (cmd_i.mem_seed) begin
      we      = 1'b1;
      wr_addr = IW'(1);
      wdata   = '{settled: 1'b0, reached: 1'b1, k: 32'd0, d: 32'd1};
    end else if (cmd_i.settle_wr) begin
      we      = 1'b1;
      wr_addr = best_idx_q;
      wdata   = '{settled: 1'b1, reached: 1'b1, k: best_k_q, d: best_d_q};
    end else if (cmd_i.wr_y || cmd_i.wr_z) begin
      we      = better;
      wr_addr = to_s;
      wdata   = '{settled: rdata_q.settled, reached: 1'b1, k: nk, d: nd[31:0]};
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_v_q    <= 1'b0;
      sum_v_q     <= 1'b0;
      acc_v_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      scan_v_q <= cmd_i.scan_rd;
      sum_v_q  <= cmd_i.sum_rd;
      acc_v_q  <= sum_v_q;
      if (cmd_i.best_clr) begin
        found_q <= 1'b0;
      end else if (scan_v_q && rdata_q.reached && !rdata_q.settled &&
                   (!found_q || rdata_q.d < best_d_q)) begin
        found_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // d = k*x + r, so d <= h compares k and r against h/x and h%x
  assign in_range = rdata_q.reached &&
                    ((HW'(rdata_q.k) < q_h_q) ||
                     ((HW'(rdata_q.k) == q_h_q) && (32'(eval_idx_q) <= 32'(r_h_q))));

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd || cmd_i.sum_rd) begin
      eval_idx_q <= idx_q;
    end
    if (scan_v_q && rdata_q.reached && !rdata_q.settled &&
        (!found_q || rdata_q.d < best_d_q)) begin
      best_idx_q <= eval_idx_q;
      best_k_q   <= rdata_q.k;
      best_d_q   <= rdata_q.d;
    end
    addend_q <= (sum_v_q && in_range) ?
                q_h_q - HW'(rdata_q.k) + HW'(32'(eval_idx_q) <= 32'(r_h_q)) : '0;
    if (cmd_i.total_clr) begin
      total_q <= '0;
    end else if (acc_v_q) begin
      total_q <= total_q + addend_q;
    end
    if (cmd_i.load_out) begin
      priority if (unit_c) begin
        out_data_q <= '{reachable_count: item_q.height_limit, modulus_too_large: 1'b0};
      end else if (xzero_c) begin
        out_data_q <= '{reachable_count: '0, modulus_too_large: 1'b0};
      end else if (too_c) begin
        out_data_q <= '{reachable_count: '0, modulus_too_large: 1'b1};
      end else begin
        out_data_q <= '{reachable_count: total_q, modulus_too_large: 1'b0};
      end
    end
  end

  assign sts_o.special  = unit_c || xzero_c || too_c;
  assign sts_o.div_done = div_done;
  assign sts_o.idx_last = idx_q == xm1;
  assign sts_o.found    = found_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[design/rcr_ctrl.sv]
// controller state machine sequencing the search
module rcr_ctrl import rcr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  rcr_sts_t sts_i,
  output logic     in_ready_o,
  output rcr_cmd_t cmd_o
);

  typedef enum logic [18:0] {
    ST_IDLE     = 19'd1,
    ST_CLASS    = 19'd2,
    ST_DIV_H    = 19'd4,
    ST_DIV_Y    = 19'd8,
    ST_DIV_Z    = 19'd16,
    ST_CLEAR    = 19'd32,
    ST_SEED     = 19'd64,
    ST_SCAN     = 19'd128,
    ST_SCAN_END = 19'd256,
    ST_SCAN_CHK = 19'd512,
    ST_SETTLE   = 19'd1024,
    ST_RD_Y     = 19'd2048,
    ST_WR_Y     = 19'd4096,
    ST_RD_Z     = 19'd8192,
    ST_WR_Z     = 19'd16384,
    ST_SUM      = 19'd32768,
    ST_SUM_END1 = 19'd65536,
    ST_SUM_END2 = 19'd131072,
    ST_DONE     = 19'd262144
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (sts_i.special) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_H;
          state_d         = ST_DIV_H;
        end
      end
      ST_DIV_H: begin
        if (sts_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_Y;
          state_d         = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (sts_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_Z;
          state_d         = ST_DIV_Z;
        end
      end
      ST_DIV_Z: begin
        if (sts_i.div_done) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd_o.mem_clear = 1'b1;
        cmd_o.idx_inc   = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_SEED;
        end
      end
      ST_SEED: begin
        cmd_o.mem_seed = 1'b1;
        cmd_o.idx_clr  = 1'b1;
        cmd_o.best_clr = 1'b1;
        state_d        = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (sts_i.found) begin
          state_d = ST_SETTLE;
        end else begin
          cmd_o.idx_clr   = 1'b1;
          cmd_o.total_clr = 1'b1;
          state_d         = ST_SUM;
        end
      end
      ST_SETTLE: begin
        cmd_o.settle_wr = 1'b1;
        state_d         = ST_RD_Y;
      end
      ST_RD_Y: begin
        cmd_o.rd_y = 1'b1;
        state_d    = ST_WR_Y;
      end
      ST_WR_Y: begin
        cmd_o.wr_y = 1'b1;
        state_d    = ST_RD_Z;
      end
      ST_RD_Z: begin
        cmd_o.rd_z = 1'b1;
        state_d    = ST_WR_Z;
      end
      ST_WR_Z: begin
        cmd_o.wr_z     = 1'b1;
        cmd_o.idx_clr  = 1'b1;
        cmd_o.best_clr = 1'b1;
        state_d        = ST_SCAN;
      end
      ST_SUM: begin
        cmd_o.sum_rd  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_SUM_END1;
        end
      end
      ST_SUM_END1: state_d = ST_SUM_END2;
      ST_SUM_END2: state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[design/residue_class_reachable_count_top.sv]
// top level of the residue class reachable count block
// timing: a unit step, zero or oversized modulus skips the divider runs and the search;
//   otherwise the run time grows with the modulus x, set by the divider runs, the memory
//   sweep and the one-read-per-cycle minimum scan of the memory for each reached residue
// throughput: one request at a time; a new request is taken while the result waits
// reset: asynchronous active low, clears control state; residue memory is swept each request that runs the search
module residue_class_reachable_count_top import rcr_pkg::*; #(
  parameter int unsigned RESIDUE_TABLE_SIZE = RESIDUE_TABLE_SIZE_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rcr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rcr_out_t out_data_o
);

`include "assert_macros.svh"

  // command and status between sequencer and datapath
  rcr_cmd_t cmd;
  rcr_sts_t sts;

  // sequencer: divider runs, memory sweep, scan/settle/relax loop, final sum
  rcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // datapath: distances kept as quotient and residue per memory entry
  rcr_dp #(
    .RESIDUE_TABLE_SIZE (RESIDUE_TABLE_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // a taken request blocks the next one until its result is queued
  `RCR_ASSERT_IMP(a_one_at_a_time, in_valid_i && in_ready_o, ##1 !in_ready_o, "ready after accept")
  // a result is never written over one still waiting
  `RCR_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_o || out_ready_i, "result lost")
  // at most one memory write source per cycle
  `RCR_ASSERT(a_one_writer, $onehot0({cmd.mem_clear, cmd.mem_seed, cmd.settle_wr, cmd.wr_y, cmd.wr_z}), "write clash")
  // a result appears only when the sequencer loads it
  `RCR_ASSERT_IMP(a_out_source, $rose(out_valid_o), $past(cmd.load_out), "stray result")

endmodule
